FILE: rtl/core/sfra_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfra_pkg
// Shared constants, types and index table for the serial frame register agent.
// ----------------------------------------------------------------------------
package sfra_pkg;

	localparam int MAX_PAYLOAD = 16;
	localparam int STORE_BYTES = 256;

	localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);
	localparam int PIX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
	localparam int IDX_W = $clog2(STORE_BYTES);
	localparam int J_W   = LEN_W + 1;

	localparam logic [7:0] SYNC_A     = 8'hfe;
	localparam logic [7:0] SYNC_B     = 8'h68;
	localparam logic [7:0] CMD_WRITE  = 8'h57;
	localparam logic [7:0] CMD_STREAM = 8'h53;
	localparam logic [7:0] CMD_READ   = 8'h52;
	localparam logic [7:0] SYNC_SUM   = 8'(9'(SYNC_A) + 9'(SYNC_B));

	localparam int   ADDR_W    = 3;
	localparam logic REG_NODE  = 1'b0;
	localparam logic REG_BCAST = 1'b1;

	typedef logic [IDX_W-1:0] idx_t;
	typedef idx_t idx_tbl_t [256];

	// byte -> register index, reduced modulo the store size
	function automatic idx_tbl_t build_idx_table();
		idx_tbl_t t;
		for (int i = 0; i < 256; i++) begin
			t[i] = idx_t'(i % STORE_BYTES);
		end
		return t;
	endfunction

	localparam idx_tbl_t IDX_TABLE = build_idx_table();

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SYNC_A,
		ST_SYNC_B,
		ST_SRC,
		ST_DST,
		ST_CMD,
		ST_DATA,
		ST_CHECK,
		ST_WRITE,
		ST_STREAM,
		ST_HDR,
		ST_IDX,
		ST_VAL,
		ST_SUM
	} state_t;

	typedef struct packed {
		logic cap_src;
		logic cap_dst;
		logic cap_cmd;
		logic cap_len;
		logic cap_data;
		logic sum_init;
		logic sum_add;
		logic ex_start;
		logic w_step;
		logic s_step;
		logic h_emit;
		logic i_emit;
		logic v_emit;
		logic c_emit;
	} dp_cmd_t;

	typedef struct packed {
		logic rx_sync_a;
		logic rx_sync_b;
		logic len_ok;
		logic len_zero;
		logic data_last;
		logic frame_ok;
		logic cmd_write;
		logic cmd_stream;
		logic cmd_read;
		logic more_pairs;
		logic more_reads;
		logic hdr_last;
		logic out_free;
	} dp_stat_t;

endpackage

FILE: rtl/core/sfra_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfra_cfg
// Bus-side register file: node and broadcast addresses.
// ----------------------------------------------------------------------------
module sfra_cfg
	import sfra_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output logic [7:0]        node_address,
	output logic [7:0]        broadcast_address
);

	logic [7:0] node_q;
	logic [7:0] bcast_q;
	logic       wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_q  <= 8'd0;
			bcast_q <= 8'hff;
		end else if (wr_en) begin
			case (paddr[2])
				REG_NODE:  node_q  <= pwdata[7:0];
				REG_BCAST: bcast_q <= pwdata[7:0];
				default:   node_q  <= node_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_NODE:  prdata = {24'd0, node_q};
			REG_BCAST: prdata = {24'd0, bcast_q};
			default:   prdata = 32'd0;
		endcase
	end

	assign node_address      = node_q;
	assign broadcast_address = bcast_q;

endmodule

FILE: rtl/core/sfra_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfra_ctrl
// Frame parser and command sequencer state machine.
// ----------------------------------------------------------------------------
module sfra_ctrl
	import sfra_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	state_t state_q;
	state_t state_d;
	logic   acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		acc      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				acc      = in_valid;
				if (acc && stat.rx_sync_a) state_d = ST_SYNC_A;
			end
			ST_SYNC_A: begin
				in_ready = 1'b1;
				acc      = in_valid;
				if (acc) begin
					if (stat.rx_sync_b) begin
						cmd.sum_init = 1'b1;
						state_d      = ST_SYNC_B;
					end else if (!stat.rx_sync_a) begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_SYNC_B: begin
				in_ready = 1'b1;
				acc      = in_valid;
				if (acc) begin
					cmd.cap_src = 1'b1;
					cmd.sum_add = 1'b1;
					state_d     = ST_SRC;
				end
			end
			ST_SRC: begin
				in_ready = 1'b1;
				acc      = in_valid;
				if (acc) begin
					cmd.cap_dst = 1'b1;
					cmd.sum_add = 1'b1;
					state_d     = ST_DST;
				end
			end
			ST_DST: begin
				in_ready = 1'b1;
				acc      = in_valid;
				if (acc) begin
					cmd.cap_cmd = 1'b1;
					cmd.sum_add = 1'b1;
					state_d     = ST_CMD;
				end
			end
			ST_CMD: begin
				in_ready = 1'b1;
				acc      = in_valid;
				if (acc) begin
					if (stat.len_ok) begin
						cmd.cap_len = 1'b1;
						cmd.sum_add = 1'b1;
						state_d     = stat.len_zero ? ST_CHECK : ST_DATA;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_DATA: begin
				in_ready = 1'b1;
				acc      = in_valid;
				if (acc) begin
					cmd.cap_data = 1'b1;
					cmd.sum_add  = 1'b1;
					if (stat.data_last) state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				in_ready = 1'b1;
				acc      = in_valid;
				if (acc) begin
					state_d = ST_IDLE;
					if (stat.frame_ok) begin
						cmd.ex_start = 1'b1;
						if (stat.cmd_write)       state_d = ST_WRITE;
						else if (stat.cmd_stream) state_d = ST_STREAM;
						else if (stat.cmd_read)   state_d = ST_HDR;
					end
				end
			end
			ST_WRITE: begin
				if (stat.more_pairs) cmd.w_step = 1'b1;
				else                 state_d    = ST_IDLE;
			end
			ST_STREAM: begin
				if (stat.more_pairs) cmd.s_step = 1'b1;
				else                 state_d    = ST_IDLE;
			end
			ST_HDR: begin
				if (stat.out_free) begin
					cmd.h_emit = 1'b1;
					if (stat.hdr_last) state_d = ST_IDX;
				end
			end
			ST_IDX: begin
				if (!stat.more_reads) begin
					state_d = ST_SUM;
				end else if (stat.out_free) begin
					cmd.i_emit = 1'b1;
					state_d    = ST_VAL;
				end
			end
			ST_VAL: begin
				if (stat.out_free) begin
					cmd.v_emit = 1'b1;
					state_d    = ST_IDX;
				end
			end
			ST_SUM: begin
				if (stat.out_free) begin
					cmd.c_emit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// the sequencer never takes a byte while working a frame
	a_no_rx_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.w_step || cmd.s_step || cmd.h_emit || cmd.i_emit || cmd.v_emit || cmd.c_emit)
		|-> !in_ready)
		else $error("byte accepted during frame execution");

	a_sum_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.c_emit |=> state_q == ST_IDLE)
		else $error("reply checksum did not end the sequence");

	a_exec_needs_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHECK && acc && !stat.frame_ok) |=> state_q == ST_IDLE)
		else $error("rejected frame not dropped");

endmodule

FILE: rtl/core/sfra_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfra_dp
// Frame fields, payload buffer, running checksums, register store, reply
// output register.
// ----------------------------------------------------------------------------
module sfra_dp
	import sfra_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] in_data,
	input  logic [7:0] node_address,
	input  logic [7:0] broadcast_address,
	input  dp_cmd_t    cmd,
	output dp_stat_t   stat,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,
	output logic       m_tlast
);

	localparam logic [2:0] H_SYNC_A = 3'd0;
	localparam logic [2:0] H_SYNC_B = 3'd1;
	localparam logic [2:0] H_NODE   = 3'd2;
	localparam logic [2:0] H_DEST   = 3'd3;
	localparam logic [2:0] H_CMD    = 3'd4;
	localparam logic [2:0] H_LEN    = 3'd5;

	logic [7:0]       src_q;
	logic [7:0]       dst_q;
	logic [7:0]       cmd_q;
	logic [LEN_W-1:0] len_q;
	logic [LEN_W-1:0] cnt_q;
	logic [7:0]       pay_q [MAX_PAYLOAD];
	logic [7:0]       rsum_q;
	logic [7:0]       tsum_q;
	logic [J_W-1:0]   j_q;
	logic [2:0]       hcnt_q;
	idx_t             widx_q;

	logic [7:0]       mem [STORE_BYTES];
	logic [STORE_BYTES-1:0] valid_q;
	logic [7:0]       rd_data_s1;
	logic             rd_valid_s1;

	logic             out_valid_q;
	logic [7:0]       out_data_q;
	logic             out_last_q;

	logic [J_W-1:0]   j1;
	logic [7:0]       pay_j;
	logic [7:0]       pay_j1;
	logic [LEN_W:0]   cnt_next;
	logic             we;
	idx_t             waddr;
	logic [7:0]       wdata;
	idx_t             raddr;
	logic             emit;
	logic [7:0]       hdr_byte;
	logic [7:0]       tx_byte;
	logic [7:0]       rd_value;
	logic             csum_ok;

	assign j1       = j_q + J_W'(1);
	assign pay_j    = pay_q[j_q[PIX_W-1:0]];
	assign pay_j1   = pay_q[j1[PIX_W-1:0]];
	assign cnt_next = {1'b0, cnt_q} + (LEN_W + 1)'(1);
	assign csum_ok  = 8'(rsum_q + in_data) == 8'd0;
	assign rd_value = rd_valid_s1 ? rd_data_s1 : 8'd0;

	always_comb begin
		stat.rx_sync_a  = in_data == SYNC_A;
		stat.rx_sync_b  = in_data == SYNC_B;
		stat.len_ok     = in_data <= 8'(MAX_PAYLOAD);
		stat.len_zero   = in_data == 8'd0;
		stat.data_last  = cnt_next >= {1'b0, len_q};
		stat.frame_ok   = csum_ok && (dst_q == node_address || dst_q == broadcast_address);
		stat.cmd_write  = cmd_q == CMD_WRITE;
		stat.cmd_stream = cmd_q == CMD_STREAM;
		stat.cmd_read   = cmd_q == CMD_READ;
		stat.more_pairs = j1 < J_W'(len_q);
		stat.more_reads = j_q < J_W'(len_q);
		stat.hdr_last   = hcnt_q == H_LEN;
		stat.out_free   = !out_valid_q || m_tready;
	end

	// frame capture and checksum
	always_ff @(posedge clk) begin
		if (cmd.cap_src) src_q <= in_data;
		if (cmd.cap_dst) dst_q <= in_data;
		if (cmd.cap_cmd) cmd_q <= in_data;
		if (cmd.cap_data) pay_q[cnt_q[PIX_W-1:0]] <= in_data;
		if (cmd.sum_init)     rsum_q <= SYNC_SUM;
		else if (cmd.sum_add) rsum_q <= 8'(rsum_q + in_data);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			cnt_q <= '0;
		end else if (cmd.cap_len) begin
			len_q <= in_data[LEN_W-1:0];
			cnt_q <= '0;
		end else if (cmd.cap_data) begin
			cnt_q <= cnt_next[LEN_W-1:0];
		end
	end

	// execution counters
	always_ff @(posedge clk) begin
		if (cmd.ex_start) begin
			j_q    <= '0;
			hcnt_q <= H_SYNC_A;
			widx_q <= IDX_TABLE[pay_q[0]];
			tsum_q <= 8'd0;
		end else begin
			if (cmd.w_step)                     j_q <= j_q + J_W'(2);
			else if (cmd.s_step || cmd.v_emit)  j_q <= j1;
			if (cmd.h_emit) hcnt_q <= hcnt_q + 3'd1;
			if (cmd.s_step) begin
				widx_q <= (widx_q == idx_t'(STORE_BYTES - 1)) ? '0 : widx_q + idx_t'(1);
			end
			if (cmd.h_emit || cmd.i_emit || cmd.v_emit) tsum_q <= 8'(tsum_q + tx_byte);
		end
	end

	// register store: one write port, one registered read port
	assign we    = cmd.w_step || cmd.s_step;
	assign waddr = cmd.s_step ? widx_q : IDX_TABLE[pay_j];
	assign wdata = pay_j1;
	assign raddr = IDX_TABLE[pay_j];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rd_data_s1  <= mem[raddr];
		rd_valid_s1 <= valid_q[raddr];
	end

	// entries never written read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (we) begin
			valid_q[waddr] <= 1'b1;
		end
	end

	always_comb begin
		case (hcnt_q)
			H_SYNC_A: hdr_byte = SYNC_A;
			H_SYNC_B: hdr_byte = SYNC_B;
			H_NODE:   hdr_byte = dst_q;
			H_DEST:   hdr_byte = src_q;
			H_CMD:    hdr_byte = CMD_WRITE;
			H_LEN:    hdr_byte = 8'({len_q, 1'b0});
			default:  hdr_byte = 8'd0;
		endcase
	end

	always_comb begin
		tx_byte = hdr_byte;
		if (cmd.i_emit)      tx_byte = pay_j;
		else if (cmd.v_emit) tx_byte = rd_value;
		else if (cmd.c_emit) tx_byte = 8'd0 - tsum_q;
	end

	assign emit = cmd.h_emit || cmd.i_emit || cmd.v_emit || cmd.c_emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_data_q <= tx_byte;
			out_last_q <= cmd.c_emit;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> (!out_valid_q || m_tready))
		else $error("reply byte overwritten before it was taken");

	a_no_write_in_reply: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> !emit)
		else $error("store written while a reply is emitted");

	a_last_marked: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.c_emit |=> (m_tvalid && m_tlast))
		else $error("checksum byte not flagged as last");

endmodule

FILE: rtl/core/serial_frame_register_agent_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_frame_register_agent_unit
// Framed register-access agent for a byte-serial bus.
// ----------------------------------------------------------------------------
// Received bytes enter on the s_ side, one per cycle while a frame is being
// parsed (0xfe 0x68 src dst cmd len data checksum). After the checksum byte
// the sequencer holds s_tready low while it works the frame through the single
// write port of the register store: 'W' writes one index/value pair per step,
// 'S' one value per step at consecutive indices; other or rejected frames go
// straight back to idle. 'R' sends its 7 + 2n byte reply on the m_ side at one
// byte per cycle while m_tready is high, with an idle step before the checksum;
// m_tlast marks the checksum.
// The store reads as zero after reset through per-entry valid flags, so there
// is no clearing pass. Registers: node address at 0x0, broadcast at 0x4.
// ----------------------------------------------------------------------------
module serial_frame_register_agent_unit
	import sfra_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,  // [7:0] rx_byte
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [7:0]        m_tdata,  // [7:0] tx_byte
	output logic              m_tlast   // last_byte
);

	logic [7:0] node_address;
	logic [7:0] broadcast_address;
	dp_cmd_t    cmd;
	dp_stat_t   stat;

	sfra_cfg u_cfg (
		.clk               (clk),
		.arst_n            (arst_n),
		.psel              (psel),
		.penable           (penable),
		.pwrite            (pwrite),
		.paddr             (paddr),
		.pwdata            (pwdata),
		.prdata            (prdata),
		.pready            (pready),
		.node_address      (node_address),
		.broadcast_address (broadcast_address)
	);

	sfra_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	sfra_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_data           (s_tdata),
		.node_address      (node_address),
		.broadcast_address (broadcast_address),
		.cmd               (cmd),
		.stat              (stat),
		.m_tvalid          (m_tvalid),
		.m_tready          (m_tready),
		.m_tdata           (m_tdata),
		.m_tlast           (m_tlast)
	);

endmodule

FILE: tb/tb_serial_frame_register_agent_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_serial_frame_register_agent_unit
// Self-checking bench for the framed register-access agent.
// ----------------------------------------------------------------------------
// Received bytes are queued as whole frames, broken frames and line noise and
// fed to the s_ side, in random bursts where gaps are on. A cycle-free model
// of the frame parser and register store follows every accepted byte and
// queues the reply bytes it predicts. With stalls on, the m_ side stalls on a
// rotating pattern. Every reply byte is checked against the model. The node
// and broadcast addresses change between phases, once the block has gone quiet.
// ----------------------------------------------------------------------------
module tb_serial_frame_register_agent_unit;
	import sfra_pkg::*;

	localparam int SETTLE_CYCLES  = 64;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_BYTES    = 55;

	typedef enum int {
		FLAW_NONE,
		FLAW_SUM,
		FLAW_CUT
	} flaw_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} tx_beat_t;

	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              psel     = 1'b0;
	logic              penable  = 1'b0;
	logic              pwrite   = 1'b0;
	logic [ADDR_W-1:0] paddr    = '0;
	logic [31:0]       pwdata   = '0;
	logic [31:0]       prdata;
	logic              pready;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [7:0]        s_tdata  = '0;  // [7:0] rx_byte
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [7:0]        m_tdata;        // [7:0] tx_byte
	logic              m_tlast;        // last_byte

	serial_frame_register_agent_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always #2 clk = ~clk;

	// model of the agent
	state_t           mdl_phase;
	logic [7:0]       mdl_src;
	logic [7:0]       mdl_dst;
	logic [7:0]       mdl_cmd;
	logic [LEN_W-1:0] mdl_len;
	logic [LEN_W-1:0] mdl_cnt;
	logic [7:0]       mdl_payload [MAX_PAYLOAD];
	logic [7:0]       mdl_regs [STORE_BYTES];
	logic [7:0]       cfg_node;
	logic [7:0]       cfg_bcast;

	tx_beat_t   reply_due [$];
	logic [7:0] rx_pending [$];
	int         rx_pushed   = 0;
	int         rx_accepted = 0;
	int         mismatch_count = 0;
	int         idle_cycles = 0;

	// sender and receiver pacing
	logic       rx_taken   = 1'b0;
	logic       rx_gaps_on = 1'b0;
	logic       tx_stall_on = 1'b0;
	int         burst_left = 0;
	int         gap_left   = 0;
	logic [7:0] stall_pat  = 8'hff;

	function automatic void expect_tx(input logic [7:0] b, input logic last);
		tx_beat_t beat;
		beat.data = b;
		beat.last = last;
		reply_due.push_back(beat);
	endfunction

	function automatic void apply_frame();
		logic [7:0] sum;
		logic [7:0] v;
		int         j;
		if (mdl_cmd == CMD_WRITE) begin
			for (j = 0; j + 1 < int'(mdl_len); j += 2)
				mdl_regs[int'(mdl_payload[j]) % STORE_BYTES] = mdl_payload[j + 1];
		end else if (mdl_cmd == CMD_STREAM) begin
			// index wraps around the store
			for (j = 1; j < int'(mdl_len); j++)
				mdl_regs[(int'(mdl_payload[0]) + j - 1) % STORE_BYTES] = mdl_payload[j];
		end else if (mdl_cmd == CMD_READ) begin
			sum = SYNC_A + SYNC_B + mdl_dst + mdl_src + CMD_WRITE + 8'(mdl_len * 2);
			expect_tx(SYNC_A, 1'b0);
			expect_tx(SYNC_B, 1'b0);
			expect_tx(mdl_dst, 1'b0);
			expect_tx(mdl_src, 1'b0);
			expect_tx(CMD_WRITE, 1'b0);
			expect_tx(8'(mdl_len * 2), 1'b0);
			for (j = 0; j < int'(mdl_len); j++) begin
				v = mdl_regs[int'(mdl_payload[j]) % STORE_BYTES];
				expect_tx(mdl_payload[j], 1'b0);
				expect_tx(v, 1'b0);
				sum = sum + mdl_payload[j] + v;
			end
			expect_tx(8'(8'h00 - sum), 1'b1);
		end
	endfunction

	function automatic void track_rx_byte(input logic [7:0] c);
		logic [7:0] sum;
		int         j;
		case (mdl_phase)
			ST_IDLE: begin
				if (c == SYNC_A)
					mdl_phase = ST_SYNC_A;
			end
			ST_SYNC_A: begin
				if (c == SYNC_B)
					mdl_phase = ST_SYNC_B;
				else if (c != SYNC_A)
					mdl_phase = ST_IDLE;
			end
			ST_SYNC_B: begin
				mdl_src   = c;
				mdl_phase = ST_SRC;
			end
			ST_SRC: begin
				mdl_dst   = c;
				mdl_phase = ST_DST;
			end
			ST_DST: begin
				mdl_cmd   = c;
				mdl_phase = ST_CMD;
			end
			ST_CMD: begin
				if (int'(c) <= MAX_PAYLOAD) begin
					mdl_len   = LEN_W'(c);
					mdl_cnt   = '0;
					mdl_phase = (c == 8'h00) ? ST_CHECK : ST_DATA;
				end else begin
					mdl_phase = ST_IDLE;
				end
			end
			ST_DATA: begin
				mdl_payload[mdl_cnt] = c;
				mdl_cnt = mdl_cnt + 1'b1;
				if (mdl_cnt >= mdl_len)
					mdl_phase = ST_CHECK;
			end
			default: begin
				mdl_phase = ST_IDLE;
				sum = SYNC_A + SYNC_B + mdl_src + mdl_dst + mdl_cmd + 8'(mdl_len);
				for (j = 0; j < int'(mdl_len); j++)
					sum = sum + mdl_payload[j];
				if (8'(sum + c) == 8'h00 && (mdl_dst == cfg_node || mdl_dst == cfg_bcast))
					apply_frame();
			end
		endcase
	endfunction

	// ------------------------------------------------------------------
	// stimulus builders
	// ------------------------------------------------------------------
	function automatic void queue_rx(input logic [7:0] b);
		rx_pending.push_back(b);
		rx_pushed++;
	endfunction

	function automatic void queue_frame(input logic [7:0] src, input logic [7:0] dst,
			input logic [7:0] cmd, input logic [7:0] body [$], input flaw_t flaw);
		logic [7:0] frame [$];
		logic [7:0] sum;
		int         cut;
		frame = '{SYNC_A, SYNC_B, src, dst, cmd, 8'(body.size())};
		foreach (body[i])
			frame.push_back(body[i]);
		sum = 8'h00;
		foreach (frame[i])
			sum = sum + frame[i];
		sum = 8'(8'h00 - sum);
		if (flaw == FLAW_SUM)
			sum = sum ^ 8'($urandom_range(1, 255));
		frame.push_back(sum);
		if (flaw == FLAW_CUT) begin
			cut = $urandom_range(2, frame.size() - 1);
			while (frame.size() > cut)
				void'(frame.pop_back());
		end
		foreach (frame[i])
			queue_rx(frame[i]);
	endfunction

	function automatic logic [7:0] pick_index();
		return ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 15)) : 8'($urandom);
	endfunction

	function automatic void queue_random_frame();
		logic [7:0] body [$];
		logic [7:0] dst;
		logic [7:0] cmd;
		int         n;
		int         roll;
		flaw_t      flaw;
		roll = $urandom_range(0, 9);
		dst  = (roll < 4) ? cfg_node : (roll < 7) ? cfg_bcast : 8'($urandom);
		roll = $urandom_range(0, 19);
		cmd  = (roll < 7) ? CMD_READ : (roll < 13) ? CMD_WRITE :
			(roll < 18) ? CMD_STREAM : 8'($urandom);
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, MAX_PAYLOAD) : $urandom_range(0, 6);
		for (int i = 0; i < n; i++) begin
			if ((cmd == CMD_STREAM && i > 0) || (cmd == CMD_WRITE && i % 2 == 1))
				body.push_back(8'($urandom));
			else
				body.push_back(pick_index());
		end
		roll = $urandom_range(0, 19);
		flaw = (roll == 0) ? FLAW_SUM : (roll == 1) ? FLAW_CUT : FLAW_NONE;
		queue_frame(8'($urandom), dst, cmd, body, flaw);
	endfunction

	// ------------------------------------------------------------------
	// config port
	// ------------------------------------------------------------------
	task automatic apb_access(input logic [ADDR_W-1:0] addr, input logic wr,
			input logic [31:0] wdata, output logic [31:0] rdata);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic write_reg(input logic idx, input logic [7:0] value);
		logic [ADDR_W-1:0] addr;
		logic [31:0]       rd;
		addr = ADDR_W'({idx, 2'b00});
		apb_access(addr, 1'b1, {24'h0, value}, rd);
		if (idx == REG_NODE)
			cfg_node = value;
		else
			cfg_bcast = value;
		apb_access(addr, 1'b0, 32'h0, rd);
		if (rd !== {24'h0, value}) begin
			$error("prdata: expected %08h, got %08h", {24'h0, value}, rd);
			mismatch_count++;
		end
	endtask

	// wait for every request to be taken and every reply byte to come back
	task automatic wait_quiet();
		do @(negedge clk); while (rx_accepted != rx_pushed || reply_due.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic run_random_phase(input logic [7:0] node, input logic [7:0] bcast,
			input logic gaps, input logic stalls);
		int start;
		int roll;
		write_reg(REG_NODE, node);
		write_reg(REG_BCAST, bcast);
		rx_gaps_on  = gaps;
		tx_stall_on = stalls;
		start = rx_pushed;
		while (rx_pushed - start < PHASE_BYTES) begin
			roll = $urandom_range(0, 19);
			if (roll < 15) begin
				if (roll == 0)
					queue_rx(SYNC_A);  // extra sync ahead of the frame
				queue_random_frame();
			end else if (roll < 17) begin
				repeat ($urandom_range(1, 6))
					queue_rx(8'($urandom));
			end else if (roll < 19) begin
				queue_rx(SYNC_A);
				queue_rx(8'($urandom));
			end else begin
				// length over the payload limit
				queue_rx(SYNC_A);
				queue_rx(SYNC_B);
				queue_rx(8'($urandom));
				queue_rx(cfg_node);
				queue_rx(CMD_WRITE);
				queue_rx(8'($urandom_range(MAX_PAYLOAD + 1, 255)));
			end
		end
		wait_quiet();
	endtask

	task automatic run_directed();
		logic [7:0] body [$];
		queue_rx(8'h00);
		queue_rx(8'hff);
		queue_rx(SYNC_A);
		queue_rx(8'h12);
		queue_rx(SYNC_A);
		queue_rx(SYNC_A);
		body = '{8'h10, 8'haa, 8'h20, 8'h55, 8'h10, 8'h5a};
		queue_frame(8'h01, cfg_node, CMD_WRITE, body, FLAW_NONE);
		body = '{8'h10, 8'h20, 8'h30};
		queue_frame(8'h02, cfg_bcast, CMD_READ, body, FLAW_NONE);
		body = '{8'hfe, 8'h11, 8'h22, 8'h33, 8'h44};
		queue_frame(8'hff, cfg_node, CMD_STREAM, body, FLAW_NONE);
		body = '{8'hfe, 8'hff, 8'h00, 8'h01};
		queue_frame(8'h80, cfg_node, CMD_READ, body, FLAW_NONE);
		body = '{8'h40, 8'h77, 8'h41};
		queue_frame(8'h03, cfg_node, CMD_WRITE, body, FLAW_NONE);
		body = '{8'h50};
		queue_frame(8'h03, cfg_node, CMD_STREAM, body, FLAW_NONE);
		body.delete();
		queue_frame(8'h03, cfg_node, CMD_STREAM, body, FLAW_NONE);
		queue_frame(8'h00, cfg_node, CMD_READ, body, FLAW_NONE);
		body = '{8'h40, 8'h00};
		queue_frame(8'h03, cfg_node, 8'h58, body, FLAW_NONE);
		body = '{8'h40, 8'h99};
		queue_frame(8'h03, cfg_node, CMD_WRITE, body, FLAW_SUM);
		queue_frame(8'h03, 8'h12, CMD_WRITE, body, FLAW_NONE);
		queue_rx(SYNC_A);
		queue_rx(SYNC_B);
		queue_rx(8'h03);
		queue_rx(cfg_node);
		queue_rx(CMD_WRITE);
		queue_rx(8'(MAX_PAYLOAD + 1));
		queue_rx(8'h00);
		queue_rx(8'h00);
		// same index twice: the later value sticks
		body = '{8'h60, 8'h00, 8'h60, 8'hff, 8'h61, 8'h80, 8'h62, 8'h7f,
			8'h63, 8'h01, 8'h64, 8'hfe, 8'h65, 8'h55, 8'h66, 8'haa};
		queue_frame(8'h04, cfg_bcast, CMD_WRITE, body, FLAW_NONE);
		body = '{8'h40, 8'h41, 8'h50, 8'h60, 8'h61, 8'h62, 8'h63, 8'h64,
			8'h65, 8'h66, 8'h10, 8'h20, 8'hfe, 8'hff, 8'h00, 8'hc8};
		queue_frame(8'hff, cfg_node, CMD_READ, body, FLAW_NONE);
		wait_quiet();
	endtask

	// ------------------------------------------------------------------
	// driver: s_ side at the falling edge, receiver stall pattern
	// ------------------------------------------------------------------
	always @(negedge clk) begin : drive_ports
		logic       nv;
		logic [7:0] nd;
		nv = s_tvalid;
		nd = s_tdata;
		if (!s_tvalid || rx_taken) begin
			nv = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
			end else if (rx_pending.size() > 0) begin
				nd = rx_pending.pop_front();
				nv = 1'b1;
				if (burst_left > 1) begin
					burst_left--;
				end else if (rx_gaps_on) begin
					burst_left = $urandom_range(1, 12);
					gap_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 40) :
						$urandom_range(0, 3);
				end else begin
					burst_left = 1;
					gap_left   = 0;
				end
			end
		end
		s_tvalid <= nv;
		s_tdata  <= nd;

		stall_pat = {stall_pat[0], stall_pat[7:1]};
		if ($urandom_range(0, 15) == 0)
			stall_pat = 8'($urandom) | 8'h01;
		m_tready <= tx_stall_on ? stall_pat[0] : 1'b1;
	end

	// ------------------------------------------------------------------
	// monitor: requests feed the model, reply bytes are checked
	// ------------------------------------------------------------------
	always @(posedge clk) begin : watch_ports
		tx_beat_t want;
		rx_taken <= arst_n && s_tvalid && s_tready;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				track_rx_byte(s_tdata);
				rx_accepted <= rx_accepted + 1;
			end
			if (m_tvalid && m_tready) begin
				if (reply_due.size() == 0) begin
					$error("unexpected reply byte: tx_byte %02h last_byte %0b",
						m_tdata, m_tlast);
					mismatch_count++;
				end else begin
					want = reply_due.pop_front();
					if (m_tdata !== want.data) begin
						$error("tx_byte: expected %02h, got %02h", want.data, m_tdata);
						mismatch_count++;
					end
					if (m_tlast !== want.last) begin
						$error("last_byte: expected %0b, got %0b", want.last, m_tlast);
						mismatch_count++;
					end
				end
			end
		end
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_serial_frame_register_agent_unit: errors");
			$finish;
		end
	end

	initial begin : run_test
		mdl_phase = ST_IDLE;
		mdl_src   = '0;
		mdl_dst   = '0;
		mdl_cmd   = '0;
		mdl_len   = '0;
		mdl_cnt   = '0;
		cfg_node  = 8'h00;
		cfg_bcast = 8'hff;
		for (int i = 0; i < MAX_PAYLOAD; i++)
			mdl_payload[i] = '0;
		for (int i = 0; i < STORE_BYTES; i++)
			mdl_regs[i] = '0;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		write_reg(REG_NODE, 8'h00);
		write_reg(REG_BCAST, 8'hff);
		run_directed();

		run_random_phase(8'h5a, 8'h00, 1'b1, 1'b1);
		run_random_phase(8'hff, 8'h80, 1'b1, 1'b0);
		run_random_phase(8'h01, 8'h01, 1'b0, 1'b1);
		run_random_phase(8'h33, 8'hff, 1'b1, 1'b1);

		if (mismatch_count == 0)
			$display("tb_serial_frame_register_agent_unit: clean");
		else
			$display("tb_serial_frame_register_agent_unit: errors");
		$finish;
	end

endmodule

FILE: sim.f
rtl/core/sfra_pkg.sv
rtl/core/sfra_cfg.sv
rtl/core/sfra_ctrl.sv
rtl/core/sfra_dp.sv
rtl/core/serial_frame_register_agent_unit.sv
tb/tb_serial_frame_register_agent_unit.sv
